// ===== rtl/jtgc_pkg.sv =====
// Shared definitions for the JSON token grammar checker: sizes, token kinds,
// return-stack codes, result status codes and the structs between the stack and the FSM.
// No dependencies.
`default_nettype none

package jtgc_pkg;

    // Stack sizing: the depth limit and the widths derived from it.
    localparam int MAX_DEPTH = 512;
    localparam int ADDR_W    = $clog2(MAX_DEPTH);
    localparam int COUNT_W   = $clog2(MAX_DEPTH + 1);

    // Field widths of the token and result transfers.
    localparam int KIND_W    = 4;
    localparam int LINE_W    = 16;
    localparam int STATUS_W  = 2;
    localparam int DEPTH_W   = 9;
    localparam int DEPTH_MAX = (2 ** DEPTH_W) - 1;

    // Token kinds as delivered by the tokeniser.
    typedef enum logic [KIND_W-1:0] {
        TK_LBRACK  = 4'd0,
        TK_RBRACK  = 4'd1,
        TK_LBRACE  = 4'd2,
        TK_RBRACE  = 4'd3,
        TK_COLON   = 4'd4,
        TK_COMMA   = 4'd5,
        TK_STRING  = 4'd6,
        TK_NUMBER  = 4'd7,
        TK_TRUE    = 4'd8,
        TK_FALSE   = 4'd9,
        TK_NULL    = 4'd10,
        TK_EOF     = 4'd11,
        TK_INVALID = 4'd12
    } token_kind_t;

    // Return codes held on the stack.
    typedef logic [1:0] ret_code_t;
    localparam ret_code_t RET_DONE = 2'd0;
    localparam ret_code_t RET_OBJ  = 2'd1;
    localparam ret_code_t RET_ARR  = 2'd2;

    // Result status codes.
    typedef logic [STATUS_W-1:0] status_t;
    localparam status_t STATUS_ACCEPTED = 2'd0;
    localparam status_t STATUS_COMPLETE = 2'd1;
    localparam status_t STATUS_ERROR    = 2'd2;
    localparam status_t STATUS_AFTER    = 2'd3;

    // Stack operation requested by the grammar FSM for the current token.
    typedef struct packed {
        logic      push;
        logic      pop;
        ret_code_t code;
    } stack_cmd_t;

    // Stack view presented to the grammar FSM.
    typedef struct packed {
        ret_code_t          top;
        logic [COUNT_W-1:0] count;
    } stack_stat_t;

endpackage

`default_nettype wire

// ===== rtl/jtgc_stack.sv =====
// Return stack of the grammar checker: a synchronous memory of return codes with a
// top-of-stack register that bridges the registered read port. Depends on jtgc_pkg.
`default_nettype none

module jtgc_stack
    import jtgc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire stack_cmd_t  cmd,
    output stack_stat_t      stat
);

    // Return-code memory; entry zero is never written and always reads as done.
    ret_code_t mem [MAX_DEPTH];

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    ret_code_t          top_reg;
    logic               top_from_mem_reg;
    ret_code_t          rd_data_reg;
    logic               rd_base_reg;
    logic [COUNT_W-1:0] rd_addr_full;
    ret_code_t          mem_top;
    ret_code_t          top;

    // The entry below the top is read every cycle, so it is ready for a pop.
    assign rd_addr_full = count_reg - COUNT_W'(2);
    assign mem_top      = rd_base_reg ? RET_DONE : rd_data_reg;
    assign top          = top_from_mem_reg ? mem_top : top_reg;

    // Count update for the requested operation.
    always_comb
    begin
        count_next = count_reg;
        if (cmd.push)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - COUNT_W'(1);
        end
    end

    // Memory write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.push && (count_reg < COUNT_W'(MAX_DEPTH)))
        begin
            mem[count_reg[ADDR_W-1:0]] <= cmd.code;
        end
        rd_data_reg <= mem[rd_addr_full[ADDR_W-1:0]];
        rd_base_reg <= (count_reg <= COUNT_W'(2));
    end

    // Count and top-of-stack tracking. After a pop the new top arrives from the read port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= COUNT_W'(1);
            top_reg          <= RET_DONE;
            top_from_mem_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.push)
            begin
                top_reg          <= cmd.code;
                top_from_mem_reg <= 1'b0;
            end
            else if (cmd.pop)
            begin
                top_from_mem_reg <= 1'b1;
            end
            else
            begin
                top_reg          <= top;
                top_from_mem_reg <= 1'b0;
            end
        end
    end

    assign stat.top   = top;
    assign stat.count = count_reg;

endmodule

`default_nettype wire

// ===== rtl/jtgc_fsm.sv =====
// Grammar state machine of the checker: decides each token against the current state and
// top of stack, issues the stack operation and registers the result. Depends on jtgc_pkg.
`default_nettype none

module jtgc_fsm
    import jtgc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                tok_valid,
    output logic                     tok_ready,
    input  wire logic [KIND_W-1:0]   tok_kind,
    input  wire logic [LINE_W-1:0]   tok_line,
    input  wire logic                require_eof,
    input  wire stack_stat_t         stat,
    output stack_cmd_t               cmd,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output status_t                  out_status,
    output logic [DEPTH_W-1:0]       out_depth,
    output logic [LINE_W-1:0]        out_error_line
);

    typedef enum logic [3:0] {
        ST_VALUE              = 4'd0,
        ST_KEY_OR_CLOSE       = 4'd1,
        ST_COLON              = 4'd2,
        ST_OBJ_VALUE          = 4'd3,
        ST_OBJ_CLOSE_OR_COMMA = 4'd4,
        ST_ARR_VALUE_OR_CLOSE = 4'd5,
        ST_ARR_CLOSE_OR_COMMA = 4'd6,
        ST_REJECTED           = 4'd7,
        ST_DONE               = 4'd8,
        ST_FINISHED           = 4'd9
    } gstate_t;

    gstate_t             state_reg;
    gstate_t             state_next;
    logic [LINE_W-1:0]   err_line_reg;
    logic [LINE_W-1:0]   err_line_next;
    logic                out_valid_reg;
    status_t             out_status_reg;
    logic [DEPTH_W-1:0]  out_depth_reg;
    logic [LINE_W-1:0]   out_error_line_reg;
    logic                fire;
    token_kind_t         kind;
    logic                is_scalar;
    logic                is_open;
    logic [COUNT_W:0]    count_plus;
    logic [COUNT_W-1:0]  count_next;
    status_t             status_next;

    // State reached when a container or the top-level value is closed.
    function automatic gstate_t ret_state(input ret_code_t code);
        gstate_t s;
        unique case (code)
            RET_OBJ: s = ST_OBJ_CLOSE_OR_COMMA;
            RET_ARR: s = ST_ARR_CLOSE_OR_COMMA;
            default: s = ST_DONE;
        endcase
        return s;
    endfunction

    // A new token is taken whenever the result register is free or being emptied.
    assign tok_ready  = !out_valid_reg || out_ready;
    assign fire       = tok_valid && tok_ready;
    assign kind       = token_kind_t'(tok_kind);
    assign is_scalar  = (tok_kind >= KIND_W'(TK_STRING)) && (tok_kind <= KIND_W'(TK_NULL));
    assign is_open    = (kind == TK_LBRACK) || (kind == TK_LBRACE);
    assign count_plus = {1'b0, stat.count} + (COUNT_W + 1)'(1);

    // Grammar decision for the offered token.
    always_comb
    begin
        state_next    = state_reg;
        err_line_next = err_line_reg;
        cmd.push      = 1'b0;
        cmd.pop       = 1'b0;
        cmd.code      = RET_DONE;
        if (fire)
        begin
            unique case (state_reg)
                ST_VALUE:
                begin
                    if (kind == TK_LBRACK)
                        state_next = ST_ARR_VALUE_OR_CLOSE;
                    else if (kind == TK_LBRACE)
                        state_next = ST_KEY_OR_CLOSE;
                    else if (is_scalar)
                    begin
                        cmd.pop    = 1'b1;
                        state_next = ret_state(stat.top);
                    end
                    else
                        state_next = ST_REJECTED;
                end
                ST_KEY_OR_CLOSE:
                begin
                    if (kind == TK_RBRACE)
                    begin
                        cmd.pop    = 1'b1;
                        state_next = ret_state(stat.top);
                    end
                    else if (kind == TK_STRING)
                        state_next = ST_COLON;
                    else
                        state_next = ST_REJECTED;
                end
                ST_COLON:
                begin
                    if (kind == TK_COLON)
                        state_next = ST_OBJ_VALUE;
                    else
                        state_next = ST_REJECTED;
                end
                ST_OBJ_VALUE:
                begin
                    if (is_scalar)
                        state_next = ST_OBJ_CLOSE_OR_COMMA;
                    else if (is_open)
                    begin
                        cmd.push   = 1'b1;
                        cmd.code   = RET_OBJ;
                        state_next = (kind == TK_LBRACK) ? ST_ARR_VALUE_OR_CLOSE
                                                         : ST_KEY_OR_CLOSE;
                    end
                    else
                        state_next = ST_REJECTED;
                end
                ST_OBJ_CLOSE_OR_COMMA:
                begin
                    if (kind == TK_COMMA)
                        state_next = ST_KEY_OR_CLOSE;
                    else if (kind == TK_RBRACE)
                    begin
                        cmd.pop    = 1'b1;
                        state_next = ret_state(stat.top);
                    end
                    else
                        state_next = ST_REJECTED;
                end
                ST_ARR_VALUE_OR_CLOSE:
                begin
                    if (kind == TK_RBRACK)
                    begin
                        cmd.pop    = 1'b1;
                        state_next = ret_state(stat.top);
                    end
                    else if (is_scalar)
                        state_next = ST_ARR_CLOSE_OR_COMMA;
                    else if (is_open)
                    begin
                        cmd.push   = 1'b1;
                        cmd.code   = RET_ARR;
                        state_next = (kind == TK_LBRACK) ? ST_ARR_VALUE_OR_CLOSE
                                                         : ST_KEY_OR_CLOSE;
                    end
                    else
                        state_next = ST_REJECTED;
                end
                ST_ARR_CLOSE_OR_COMMA:
                begin
                    if (kind == TK_RBRACK)
                    begin
                        cmd.pop    = 1'b1;
                        state_next = ret_state(stat.top);
                    end
                    else if (kind == TK_COMMA)
                        state_next = ST_ARR_VALUE_OR_CLOSE;
                    else
                        state_next = ST_REJECTED;
                end
                ST_DONE:
                begin
                    if (require_eof && (kind != TK_EOF))
                        state_next = ST_REJECTED;
                    else
                        state_next = ST_FINISHED;
                end
                ST_FINISHED: state_next = ST_FINISHED;
                ST_REJECTED: state_next = ST_REJECTED;
                default:     state_next = ST_REJECTED;
            endcase

            // A push that brings the stack to the depth limit is an error as well.
            if (cmd.push && (count_plus >= (COUNT_W + 1)'(MAX_DEPTH)))
                state_next = ST_REJECTED;

            // Record the line of the token that first drives the machine into error.
            if ((state_next == ST_REJECTED) && (state_reg != ST_REJECTED))
                err_line_next = tok_line;
        end
    end

    // Stack count after this token and the status it reports.
    always_comb
    begin
        count_next = stat.count;
        if (cmd.push)
            count_next = count_plus[COUNT_W-1:0];
        else if (cmd.pop)
            count_next = stat.count - COUNT_W'(1);

        unique case (state_next)
            ST_REJECTED: status_next = STATUS_ERROR;
            ST_DONE:     status_next = STATUS_COMPLETE;
            ST_FINISHED: status_next = STATUS_AFTER;
            default:     status_next = STATUS_ACCEPTED;
        endcase
    end

    // State, error line and the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_VALUE;
            err_line_reg       <= '0;
            out_valid_reg      <= 1'b0;
            out_status_reg     <= STATUS_ACCEPTED;
            out_depth_reg      <= '0;
            out_error_line_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            err_line_reg <= err_line_next;
            if (fire)
            begin
                out_valid_reg  <= 1'b1;
                out_status_reg <= status_next;
                if (count_next > COUNT_W'(DEPTH_MAX))
                    out_depth_reg <= DEPTH_W'(DEPTH_MAX);
                else
                    out_depth_reg <= count_next[DEPTH_W-1:0];
                out_error_line_reg <= (status_next == STATUS_ERROR) ? err_line_next : '0;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_status     = out_status_reg;
    assign out_depth      = out_depth_reg;
    assign out_error_line = out_error_line_reg;

endmodule

`default_nettype wire

// ===== rtl/json_token_grammar_checker.sv =====
// JSON token grammar checker. One token is accepted per clock cycle while results are
// taken, each giving one result transfer; a pop does not slow this, as the entry below
// the top of stack is read every cycle and a top-of-stack register covers the
// registered read. Results pass through one output register, so a new token is taken
// in the same cycle as the previous result is taken. The return stack is a MAX_DEPTH x
// 2-bit memory with one write and one read port; its bottom entry is fixed to "done"
// in logic, so no clearing pass runs after reset. Errors are sticky; one document is
// checked per reset. The user must write require_eof only while the block is idle; it
// is not enforced. Top level: instantiates jtgc_fsm and jtgc_stack and uses jtgc_pkg.
`default_nettype none

module json_token_grammar_checker
    import jtgc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [3:0] token_kind, [19:4] line_number, [23:20] zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [1:0] status, [10:2] nesting_depth,
                                        // [26:11] error_line, [31:27] zero
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data   // require_eof
);

    logic                require_eof_reg;
    stack_cmd_t          cmd;
    stack_stat_t         stat;
    status_t             status;
    logic [DEPTH_W-1:0]  depth;
    logic [LINE_W-1:0]   error_line;

    // Configuration register, always ready.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            require_eof_reg <= 1'b0;
        else if (cfg_valid && cfg_ready)
            require_eof_reg <= cfg_data;
    end

    // Grammar decision and result register.
    jtgc_fsm u_fsm (
        .clk            (clk),
        .rst_n          (rst_n),
        .tok_valid      (s_tvalid),
        .tok_ready      (s_tready),
        .tok_kind       (s_tdata[KIND_W-1:0]),
        .tok_line       (s_tdata[KIND_W+LINE_W-1:KIND_W]),
        .require_eof    (require_eof_reg),
        .stat           (stat),
        .cmd            (cmd),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_status     (status),
        .out_depth      (depth),
        .out_error_line (error_line)
    );

    // Return stack.
    jtgc_stack u_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat)
    );

    // Result packing.
    assign m_tdata = {5'b0, error_line, depth, status};

endmodule

`default_nettype wire

// ===== rtl/jtgc_checker.sv =====
// Port-level checks for the JSON token grammar checker, attached to the top level by the
// bind statement at the end of this file. Depends on jtgc_pkg.
`default_nettype none

module jtgc_checker
    import jtgc_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [23:0] s_tdata,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready,
    input wire logic        cfg_data
);

    logic               m_xfer;
    status_t            m_status;
    logic [DEPTH_W-1:0] m_depth;
    logic [LINE_W-1:0]  m_line;
    logic               err_seen_reg;
    logic [LINE_W-1:0]  err_line_reg;
    logic               have_prev_reg;
    logic [DEPTH_W-1:0] prev_depth_reg;

    assign m_xfer   = m_tvalid && m_tready;
    assign m_status = m_tdata[1:0];
    assign m_depth  = m_tdata[10:2];
    assign m_line   = m_tdata[26:11];

    // Remember the first reported error and the depth of the last result transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_seen_reg   <= 1'b0;
            err_line_reg   <= '0;
            have_prev_reg  <= 1'b0;
            prev_depth_reg <= '0;
        end
        else if (m_xfer)
        begin
            have_prev_reg  <= 1'b1;
            prev_depth_reg <= m_depth;
            if (!err_seen_reg && (m_status == STATUS_ERROR))
            begin
                err_seen_reg <= 1'b1;
                err_line_reg <= m_line;
            end
        end
    end

    // A stalled result stays offered unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Once an error is reported every later result reports it too, with the same line.
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        err_seen_reg && m_tvalid |-> m_status == STATUS_ERROR && m_line == err_line_reg)
        else $error("error not sticky");

    // The error line is zero on every result that is not an error.
    a_line_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_status != STATUS_ERROR |-> m_line == '0)
        else $error("error line set without error");

    // One token moves the nesting depth by one level at most.
    a_depth_step: assert property (@(posedge clk) disable iff (!rst_n)
        m_xfer && have_prev_reg |->
            ({1'b0, m_depth} == {1'b0, prev_depth_reg}) ||
            ({1'b0, m_depth} == {1'b0, prev_depth_reg} + 10'd1) ||
            ({1'b0, m_depth} + 10'd1 == {1'b0, prev_depth_reg}))
        else $error("nesting depth jumped");

endmodule

bind json_token_grammar_checker jtgc_checker u_jtgc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
);

`default_nettype wire

// ===== test/jtgc_result_checker.sv =====
// Result checker for the JSON token grammar checker: tracks the pushdown grammar on every
// token transfer and compares each result transfer with the oldest prediction still owed.
// Depends on jtgc_pkg for the field widths, token kinds, return codes and status codes.
`timescale 1ns / 1ps

module jtgc_result_checker
    import jtgc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [23:0] s_tdata,   // [3:0] token_kind, [19:4] line_number, [23:20] zero
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,   // [1:0] status, [10:2] nesting_depth,
                                        // [26:11] error_line, [31:27] zero
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic        cfg_data,  // require_eof
    output int               mismatch_count,
    output int               results_owed
);

    // Grammar positions of the pushdown automaton, plus the error and completion states.
    typedef enum logic [3:0] {
        G_VALUE,
        G_KEY_OR_CLOSE,
        G_COLON,
        G_OBJ_VALUE,
        G_OBJ_NEXT,
        G_ARR_VALUE,
        G_ARR_NEXT,
        G_ERROR,
        G_DONE,
        G_FINISHED
    } grammar_t;

    typedef struct packed {
        status_t            status;
        logic [DEPTH_W-1:0] depth;
        logic [LINE_W-1:0]  error_line;
    } token_result_t;

    grammar_t           grammar;
    ret_code_t          ret_stack [0:MAX_DEPTH-1];
    logic [COUNT_W-1:0] ret_count;
    logic [LINE_W-1:0]  first_bad_line;
    logic               eof_required;
    token_result_t      owed_results [$];
    int                 result_index;

    // Prints one line per mismatch, with a cap on the output, and counts every one.
    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < 100)
            $display("[%0t] result %0d %s: got %0d, expected %0d",
                     $time, result_index, what, got, want);
        mismatch_count++;
    endtask

    // The first error is sticky, so its line is the one that stays reported.
    function automatic void note_error(input logic [LINE_W-1:0] line);
        grammar        = G_ERROR;
        first_bad_line = line;
    endfunction

    // Entering a nested container saves where to go once it closes; reaching the depth
    // limit is an error, though the code is still stored and the count still rises.
    function automatic void descend(input logic [KIND_W-1:0] kind, input ret_code_t code,
                                    input logic [LINE_W-1:0] line);
        grammar = (kind == TK_LBRACK) ? G_ARR_VALUE : G_KEY_OR_CLOSE;
        if (ret_count < MAX_DEPTH)
            ret_stack[ret_count[ADDR_W-1:0]] = code;
        ret_count = ret_count + 1'b1;
        if (ret_count >= MAX_DEPTH)
            note_error(line);
    endfunction

    // Finishing a value returns to the position saved by the enclosing container.
    function automatic void ascend();
        ret_code_t          code;
        logic [COUNT_W-1:0] idx;
        code = RET_DONE;
        if (ret_count != 0)
        begin
            idx = ret_count - 1'b1;
            if (idx < MAX_DEPTH)
                code = ret_stack[idx[ADDR_W-1:0]];
            ret_count = idx;
        end
        case (code)
            RET_OBJ: grammar = G_OBJ_NEXT;
            RET_ARR: grammar = G_ARR_NEXT;
            default: grammar = G_DONE;
        endcase
    endfunction

    // Advances the grammar by one token and returns the result it should produce.
    function automatic token_result_t predict_token(input logic [KIND_W-1:0] kind,
                                                    input logic [LINE_W-1:0] line);
        token_result_t r;
        logic          scalar;
        scalar = (kind >= TK_STRING) && (kind <= TK_NULL);
        case (grammar)
            G_VALUE:
                if (kind == TK_LBRACK)
                    grammar = G_ARR_VALUE;
                else if (kind == TK_LBRACE)
                    grammar = G_KEY_OR_CLOSE;
                else if (scalar)
                    ascend();
                else
                    note_error(line);
            G_KEY_OR_CLOSE:
                if (kind == TK_RBRACE)
                    ascend();
                else if (kind == TK_STRING)
                    grammar = G_COLON;
                else
                    note_error(line);
            G_COLON:
                if (kind == TK_COLON)
                    grammar = G_OBJ_VALUE;
                else
                    note_error(line);
            G_OBJ_VALUE:
                if (scalar)
                    grammar = G_OBJ_NEXT;
                else if (kind == TK_LBRACK || kind == TK_LBRACE)
                    descend(kind, RET_OBJ, line);
                else
                    note_error(line);
            G_OBJ_NEXT:
                if (kind == TK_COMMA)
                    grammar = G_KEY_OR_CLOSE;
                else if (kind == TK_RBRACE)
                    ascend();
                else
                    note_error(line);
            G_ARR_VALUE:
                if (kind == TK_RBRACK)
                    ascend();
                else if (scalar)
                    grammar = G_ARR_NEXT;
                else if (kind == TK_LBRACK || kind == TK_LBRACE)
                    descend(kind, RET_ARR, line);
                else
                    note_error(line);
            G_ARR_NEXT:
                if (kind == TK_RBRACK)
                    ascend();
                else if (kind == TK_COMMA)
                    grammar = G_ARR_VALUE;
                else
                    note_error(line);
            G_DONE:
                if (eof_required && kind != TK_EOF)
                    note_error(line);
                else
                    grammar = G_FINISHED;
            G_FINISHED, G_ERROR:
                ;
            default:
                grammar = G_ERROR;
        endcase

        case (grammar)
            G_ERROR:    r.status = STATUS_ERROR;
            G_DONE:     r.status = STATUS_COMPLETE;
            G_FINISHED: r.status = STATUS_AFTER;
            default:    r.status = STATUS_ACCEPTED;
        endcase
        r.depth      = (ret_count > DEPTH_MAX) ? DEPTH_W'(DEPTH_MAX) : ret_count[DEPTH_W-1:0];
        r.error_line = (r.status == STATUS_ERROR) ? first_bad_line : '0;
        return r;
    endfunction

    // Watch all three channels: register writes, result transfers and token transfers.
    always @(posedge clk or negedge rst_n)
    begin : watch
        token_result_t want;
        if (!rst_n)
        begin
            grammar        = G_VALUE;
            ret_count      = COUNT_W'(1);
            first_bad_line = '0;
            eof_required   = 1'b0;
            result_index   = 0;
            for (int i = 0; i < MAX_DEPTH; i++)
                ret_stack[i] = RET_DONE;
            owed_results.delete();
            results_owed <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                eof_required = cfg_data;

            // A result can only belong to a token taken at an earlier edge.
            if (m_tvalid && m_tready)
            begin
                if (owed_results.size() == 0)
                    report_mismatch("arrived with no token outstanding, status",
                                    int'(m_tdata[1:0]), -1);
                else
                begin
                    want = owed_results.pop_front();
                    if (m_tdata[1:0] != want.status)
                        report_mismatch("status", int'(m_tdata[1:0]), int'(want.status));
                    if (m_tdata[10:2] != want.depth)
                        report_mismatch("nesting_depth", int'(m_tdata[10:2]),
                                        int'(want.depth));
                    if (m_tdata[26:11] != want.error_line)
                        report_mismatch("error_line", int'(m_tdata[26:11]),
                                        int'(want.error_line));
                end
                result_index++;
            end

            if (s_tvalid && s_tready)
                owed_results.push_back(predict_token(s_tdata[3:0], s_tdata[19:4]));

            results_owed <= owed_results.size();
        end
    end

endmodule

// ===== test/tb.sv =====
// Testbench top for the JSON token grammar checker: builds one long JSON document token by
// token, varies require_eof and the idling on both channels, and ends the document one of
// several ways. Depends on jtgc_pkg, json_token_grammar_checker and jtgc_result_checker.
`timescale 1ns / 1ps

module tb;
    import jtgc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    // Ways the single document of the run can end; the simulator seed picks one.
    typedef enum int {
        DOC_CLOSED,
        DOC_EOF,
        DOC_EOF_MISSING,
        DOC_BAD_TOKEN,
        DOC_EARLY_EOF,
        DOC_TOO_DEEP
    } doc_end_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;   // [3:0] token_kind, [19:4] line_number, [23:20] zero
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;          // [1:0] status, [10:2] nesting_depth,
                                   // [26:11] error_line, [31:27] zero
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data  = 1'b0; // require_eof

    int       mismatch_count;
    int       results_owed;
    int       send_idle_pct   = 0;
    int       ready_stall_pct = 0;
    int       tokens_sent     = 0;
    int       cycle_count     = 0;

    // Shape of the document built so far: one entry per open container.
    int       level = 0;
    bit       is_array   [0:MAX_DEPTH];
    bit       has_member [0:MAX_DEPTH];
    doc_end_t doc_end;

    json_token_grammar_checker u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    jtgc_result_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The result side stalls at random with the current stall rate.
    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= ready_stall_pct);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("json_token_grammar_checker: mismatch");
            $finish;
        end
    end

    // One token transfer, after a random number of idle cycles.
    task automatic send_token(input logic [KIND_W-1:0] kind, input logic [LINE_W-1:0] line);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, line, kind};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        tokens_sent++;
    endtask

    task automatic send_kind(input logic [KIND_W-1:0] kind);
        send_token(kind, LINE_W'($urandom_range(0, 65535)));
    endtask

    function automatic logic [KIND_W-1:0] random_scalar();
        return KIND_W'(int'(TK_STRING) + $urandom_range(0, 4));
    endfunction

    // Lead-in of a new member: a comma after the first one, and a key in an object.
    task automatic begin_member();
        if (has_member[level])
            send_kind(TK_COMMA);
        if (!is_array[level])
        begin
            send_kind(TK_STRING);
            send_kind(TK_COLON);
        end
        has_member[level] = 1'b1;
    endtask

    task automatic open_container(input bit as_array);
        send_kind(as_array ? TK_LBRACK : TK_LBRACE);
        level++;
        is_array[level]   = as_array;
        has_member[level] = 1'b0;
    endtask

    task automatic close_container();
        send_kind(is_array[level] ? TK_RBRACK : TK_RBRACE);
        level--;
    endtask

    // Random well-formed content inside the open document; the outermost container stays
    // open, and nesting is pulled back once it reaches a dozen levels.
    task automatic grow(input int count);
        int stop_at;
        int close_pct;
        int open_pct;
        stop_at = tokens_sent + count;
        while (tokens_sent < stop_at)
        begin
            close_pct = (level >= 12) ? 45 : ((level > 1) ? 25 : 0);
            open_pct  = (level < 4) ? 40 : ((level < 12) ? 25 : 8);
            if ($urandom_range(0, 99) < close_pct)
                close_container();
            else
            begin
                begin_member();
                if ($urandom_range(0, 99) < open_pct)
                    open_container(1'($urandom_range(0, 1)));
                else
                    send_kind(random_scalar());
            end
        end
    endtask

    // Stops sending and waits until every token transfer has had its result.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
    endtask

    task automatic write_require_eof(input logic value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [KIND_W-1:0] odd_kind;
        int                dive_to;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        write_require_eof(1'b1);

        // Directed opening: every bracket, brace and scalar kind, empty containers,
        // and the extreme line numbers.
        send_idle_pct   = 15;
        ready_stall_pct = 65;
        send_token(TK_LBRACE, '0);
        level         = 1;
        is_array[1]   = 1'b0;
        has_member[1] = 1'b0;
        begin_member();
        send_kind(TK_STRING);
        begin_member();
        open_container(1'b1);
        close_container();
        begin_member();
        open_container(1'b1);
        begin_member();
        send_kind(TK_NUMBER);
        begin_member();
        send_kind(TK_FALSE);
        begin_member();
        send_kind(TK_NULL);
        begin_member();
        send_token(TK_TRUE, '1);
        begin_member();
        open_container(1'b0);
        close_container();
        close_container();
        grow(150);

        // Second phase: the sender idles more than the receiver stalls, and a deep dive
        // takes the return stack past half of its entries.
        wait_for_results();
        write_require_eof(1'b0);
        send_idle_pct   = 65;
        ready_stall_pct = 15;
        dive_to = int'($urandom_range(257, 300));
        while (level < dive_to)
        begin
            begin_member();
            open_container($urandom_range(0, 99) < 80);
        end
        grow(150);

        // Last phase without idling, then the chosen end of the document.
        wait_for_results();
        doc_end = doc_end_t'($urandom_range(0, 5));
        case (doc_end)
            DOC_CLOSED:                write_require_eof(1'b0);
            DOC_EOF, DOC_EOF_MISSING:  write_require_eof(1'b1);
            default:                   write_require_eof(1'($urandom_range(0, 1)));
        endcase
        send_idle_pct   = 0;
        ready_stall_pct = 0;
        grow(150);

        case (doc_end)
            DOC_CLOSED, DOC_EOF, DOC_EOF_MISSING:
            begin
                while (level > 0)
                    close_container();
                if (doc_end == DOC_EOF)
                    send_kind(TK_EOF);
                else if (doc_end == DOC_EOF_MISSING)
                begin
                    odd_kind = KIND_W'($urandom_range(0, 14));
                    if (odd_kind >= TK_EOF)
                        odd_kind = odd_kind + 1'b1;
                    send_kind(odd_kind);
                end
            end
            DOC_BAD_TOKEN:
                case ($urandom_range(0, 2))
                    0:       send_kind(KIND_W'($urandom_range(int'(TK_INVALID), 15)));
                    1:       send_kind(is_array[level] ? TK_RBRACE : TK_RBRACK);
                    default: send_kind(TK_COLON);
                endcase
            DOC_EARLY_EOF:
                send_kind(TK_EOF);
            default:
            begin
                // Nest arrays until the return stack hits its limit.
                begin_member();
                while (level < MAX_DEPTH)
                    open_container(1'b1);
            end
        endcase

        // Whatever follows the end of the document must leave the outcome untouched.
        repeat (20)
            send_kind(KIND_W'($urandom_range(0, 15)));

        wait_for_results();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0)
            $display("json_token_grammar_checker: match");
        else
            $display("json_token_grammar_checker: mismatch");
        $finish;
    end

endmodule
